>>> rtl/core/cre_pkg.sv
`timescale 1ns / 1ps
package cre_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int WORD_BITS   = 16;
  localparam int STRIDE      = 5;
  localparam int RAM_DEPTH   = MAX_ENTRIES * STRIDE;
  localparam int ADDR_W      = $clog2(RAM_DEPTH);
  localparam int FRAC_BITS   = 16;
  localparam logic [16:0] ONE_FX  = 17'h10000;
  localparam logic [5:0]  CNT_MAX = 6'(MAX_ENTRIES);

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  localparam logic CFG_COUNT = 1'b0;
  localparam logic CFG_MODE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SAMP,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_END,
    ST_DIV,
    ST_RD_A,
    ST_RD_B,
    ST_LAT_B,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } cre_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_LOAD,
    OP_SAMP,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_SCAN_END,
    OP_DIV,
    OP_RD_A,
    OP_RD_B,
    OP_LAT_B,
    OP_MUL,
    OP_ACC
  } cre_op_e;

  typedef struct packed {
    cre_op_e op;
  } cre_cmd_t;

  typedef struct packed {
    logic short_tbl;
    logic sampled;
    logic scan_last;
    logic div_done;
    logic comp_last;
  } cre_sts_t;

endpackage

>>> rtl/core/cre_ram.sv
`timescale 1ns / 1ps
module cre_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 160
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/cre_ctrl.sv
`timescale 1ns / 1ps
module cre_ctrl
  import cre_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     req_type_i,
  input  logic     out_stall_i,
  input  cre_sts_t sts_i,
  output cre_cmd_t cmd_o,
  output logic     in_stall_o,
  output logic     out_valid_o
);

  cre_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && req_type_i == REQ_EVAL) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        if (sts_i.short_tbl) state_d = ST_OUT;
        else if (sts_i.sampled) state_d = ST_SAMP;
        else state_d = ST_SCAN_RD;
      end
      ST_SAMP:     state_d = ST_RD_A;
      ST_SCAN_RD:  state_d = ST_SCAN_CHK;
      ST_SCAN_CHK: state_d = sts_i.scan_last ? ST_SCAN_END : ST_SCAN_RD;
      ST_SCAN_END: state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_RD_A;
      end
      ST_RD_A:  state_d = ST_RD_B;
      ST_RD_B:  state_d = ST_LAT_B;
      ST_LAT_B: state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = sts_i.comp_last ? ST_OUT : ST_RD_A;
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_NONE;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) cmd_o.op = (req_type_i == REQ_EVAL) ? OP_LOAD : OP_WRITE;
      end
      ST_SAMP:     cmd_o.op = OP_SAMP;
      ST_SCAN_RD:  cmd_o.op = OP_SCAN_RD;
      ST_SCAN_CHK: cmd_o.op = OP_SCAN_CHK;
      ST_SCAN_END: cmd_o.op = OP_SCAN_END;
      ST_DIV:      cmd_o.op = OP_DIV;
      ST_RD_A:     cmd_o.op = OP_RD_A;
      ST_RD_B:     cmd_o.op = OP_RD_B;
      ST_LAT_B:    cmd_o.op = OP_LAT_B;
      ST_MUL:      cmd_o.op = OP_MUL;
      ST_ACC:      cmd_o.op = OP_ACC;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  a_eval_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && req_type_i == REQ_EVAL) |=> state_q == ST_SETUP)
    else $error("evaluate transfer did not start setup");

  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_stall_i) |=> state_q == ST_IDLE)
    else $error("result transfer did not return to idle");

  a_acc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && sts_i.comp_last) |=> out_valid_o)
    else $error("last channel did not raise result valid");

endmodule

>>> rtl/core/cre_dp.sv
`timescale 1ns / 1ps
module cre_dp
  import cre_pkg::*;
(
  input  logic               clk_i,
  input  cre_cmd_t           cmd_i,
  input  logic [5:0]         ramp_count_i,
  input  logic [1:0]         ramp_mode_i,
  input  logic [4:0]         entry_index_i,
  input  logic [2:0]         component_i,
  input  logic [15:0]        word_value_i,
  input  logic signed [20:0] factor_i,
  output cre_sts_t           sts_o,
  output logic [15:0]        red_o,
  output logic [15:0]        green_o,
  output logic [15:0]        blue_o,
  output logic [15:0]        alpha_out_o
);

  logic signed [20:0] factor_q;
  logic [5:0]         cnt_q;
  logic               const_q, sampled_q;
  logic [4:0]         scan_k_q, seg_q, a_ent_q, b_ent_q;
  logic [15:0]        prev_q, p0_q, p1_q, den_q, rem_q, quo_q, wa_q, wb_q;
  logic               hit_q, ovr_q, div_pend_q;
  logic [3:0]         bit_q;
  logic [16:0]        t_q;
  logic [1:0]         j_q;
  logic signed [34:0] prod_q;
  logic [15:0]        res_q [4];

  logic [4:0]              last;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_addr;
  logic [WORD_BITS-1:0]    rdata;
  logic [ADDR_W-1:0]       off;
  logic [16:0]             fc;
  logic [21:0]             scaled;
  logic [4:0]              idx, nx;
  logic signed [20:0]      diff;
  logic [15:0]             den;
  logic [16:0]             r2;
  logic                    ge;
  logic [15:0]             quo_n;
  logic signed [16:0]      dab;
  logic signed [34:0]      sum;
  logic signed [20:0]      pos_s;

  function automatic logic [ADDR_W-1:0] ent_base(input logic [4:0] e);
    ent_base = ADDR_W'({e, 2'b00}) + ADDR_W'(e);
  endfunction

  assign last = 5'(cnt_q - 6'd1);
  assign off  = sampled_q ? ADDR_W'(0) : ADDR_W'(1);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    case (cmd_i.op)
      OP_WRITE: begin
        ram_we   = (component_i < 3'(STRIDE));
        ram_addr = ent_base(entry_index_i) + ADDR_W'(component_i);
      end
      OP_SCAN_RD: ram_addr = ent_base(scan_k_q);
      OP_RD_A:    ram_addr = ent_base(a_ent_q) + off + ADDR_W'(j_q);
      OP_RD_B:    ram_addr = ent_base(b_ent_q) + off + ADDR_W'(j_q);
      default:    ram_addr = '0;
    endcase
  end

  cre_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(word_value_i),
    .rdata_o(rdata)
  );

  always_comb begin
    if (factor_q < 0) fc = '0;
    else if (factor_q > $signed({4'b0, ONE_FX})) fc = ONE_FX;
    else fc = factor_q[16:0];
    scaled = 22'(fc) * 22'(last);
    idx    = (scaled[21:16] > {1'b0, last}) ? last : scaled[20:16];
    nx     = (idx == last) ? last : 5'(idx + 5'd1);
    pos_s  = $signed({5'b0, rdata});
    diff   = factor_q - $signed({5'b0, p0_q});
    den    = p1_q - p0_q;
    r2     = {rem_q, 1'b0};
    ge     = (r2 >= {1'b0, den_q});
    quo_n  = {quo_q[14:0], ge};
    dab    = $signed({1'b0, wb_q}) - $signed({1'b0, wa_q});
    sum    = $signed({3'b0, wa_q, 16'b0}) + prod_q + 35'sd32768;
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        factor_q  <= factor_i;
        cnt_q     <= (ramp_count_i > CNT_MAX) ? CNT_MAX : ramp_count_i;
        const_q   <= ramp_mode_i[0];
        sampled_q <= ramp_mode_i[1];
        scan_k_q  <= '0;
        hit_q     <= 1'b0;
        ovr_q     <= 1'b0;
        div_pend_q <= 1'b0;
        j_q       <= '0;
        a_ent_q   <= '0;
        b_ent_q   <= '0;
        t_q       <= '0;
        res_q[0]  <= '0;
        res_q[1]  <= '0;
        res_q[2]  <= '0;
        res_q[3]  <= 16'hFFFF;
      end
      OP_SAMP: begin
        a_ent_q <= idx;
        b_ent_q <= nx;
        t_q     <= const_q ? 17'd0 : {1'b0, scaled[15:0]};
      end
      OP_SCAN_CHK: begin
        if (scan_k_q != 5'd0 && factor_q >= $signed({5'b0, prev_q})) begin
          hit_q <= 1'b1;
          seg_q <= scan_k_q;
          p0_q  <= prev_q;
          p1_q  <= rdata;
        end
        if (scan_k_q == last) ovr_q <= (factor_q >= pos_s);
        prev_q   <= rdata;
        scan_k_q <= 5'(scan_k_q + 5'd1);
      end
      OP_SCAN_END: begin
        div_pend_q <= 1'b0;
        if (ovr_q) begin
          a_ent_q <= last;
          b_ent_q <= last;
          t_q     <= '0;
        end else if (hit_q) begin
          a_ent_q <= 5'(seg_q - 5'd1);
          b_ent_q <= seg_q;
          if (const_q) begin
            t_q <= '0;
          end else if (p1_q <= p0_q) begin
            t_q <= (factor_q > $signed({5'b0, p0_q})) ? ONE_FX : 17'd0;
          end else if (diff >= $signed({5'b0, den})) begin
            t_q <= ONE_FX;
          end else begin
            t_q        <= '0;
            div_pend_q <= 1'b1;
            rem_q      <= diff[15:0];
            den_q      <= den;
            quo_q      <= '0;
            bit_q      <= '0;
          end
        end else begin
          a_ent_q <= '0;
          b_ent_q <= '0;
          t_q     <= '0;
        end
      end
      OP_DIV: begin
        if (div_pend_q) begin
          rem_q <= ge ? 16'(r2 - {1'b0, den_q}) : r2[15:0];
          quo_q <= quo_n;
          bit_q <= 4'(bit_q + 4'd1);
          if (bit_q == 4'd15) begin
            t_q        <= {1'b0, quo_n};
            div_pend_q <= 1'b0;
          end
        end
      end
      OP_RD_B:  wa_q <= rdata;
      OP_LAT_B: wb_q <= rdata;
      OP_MUL:   prod_q <= 35'(dab * $signed({1'b0, t_q}));
      OP_ACC: begin
        res_q[j_q] <= sum[31:16];
        j_q        <= 2'(j_q + 2'd1);
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.short_tbl = sampled_q ? (cnt_q < 6'd2) : (cnt_q == 6'd0);
    sts_o.sampled   = sampled_q;
    sts_o.scan_last = (scan_k_q == last);
    sts_o.div_done  = !div_pend_q || (bit_q == 4'd15);
    sts_o.comp_last = (j_q == 2'd3);
  end

  assign red_o       = res_q[0];
  assign green_o     = res_q[1];
  assign blue_o      = res_q[2];
  assign alpha_out_o = res_q[3];

  a_t_range: assert property (@(posedge clk_i)
    (cmd_i.op == OP_MUL) |-> (t_q <= ONE_FX))
    else $error("interpolation weight above one");

endmodule

>>> rtl/core/color_ramp_evaluator_top.sv
`timescale 1ns / 1ps
// Color ramp evaluator.
// Input channel (in_valid_i / in_stall_o) carries write items, which store one
// Q0.16 word of a table entry, and evaluate items, which map a Q4.16 factor to
// an RGBA color on the output channel (out_valid_o / out_stall_i). A write item
// gives no result and does not raise in_stall_o. An evaluate item gives one
// result. The APB port sets ramp_count (address 0) and ramp_mode (address 4).
// One item is in work at a time: in_stall_o stays high until the result has
// been transferred. A table too short for the mode goes straight to the result.
// In sampled mode the factor picks two table entries directly; in control mode
// the stop positions are scanned through the single table RAM port and a
// bit-per-cycle divider gives the weight between two stops. Each channel then
// takes a read-multiply-add (states RD_A, RD_B, LAT_B, MUL, ACC).
// While out_stall_i is high the result holds on the outputs.
// Reset clears the APB configuration registers and the sequencer; the datapath
// registers are not reset, and table words are unknown until written.
module color_ramp_evaluator_top
  import cre_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [4:0]         entry_index_i,
  input  logic [2:0]         component_i,
  input  logic [15:0]        word_value_i,
  input  logic signed [20:0] factor_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        red_o,
  output logic [15:0]        green_o,
  output logic [15:0]        blue_o,
  output logic [15:0]        alpha_out_o
);

  logic [5:0] count_q;
  logic [1:0] mode_q;
  cre_cmd_t   cmd;
  cre_sts_t   sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == CFG_COUNT) count_q <= pwdata[5:0];
      else mode_q <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_MODE) ? {30'b0, mode_q} : {26'b0, count_q};

  cre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  cre_dp u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .ramp_count_i (count_q),
    .ramp_mode_i  (mode_q),
    .entry_index_i(entry_index_i),
    .component_i  (component_i),
    .word_value_i (word_value_i),
    .factor_i     (factor_i),
    .sts_o        (sts),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_out_o  (alpha_out_o)
  );

endmodule
